[sv/zbs_pkg.sv]
// package: shared types and constants of the zero bit stuffing codec
package zbs_pkg;

  // results one input byte can cause at most (two full bytes plus a flush)
  localparam int unsigned MAX_RES = 3;
  // entries of the queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  typedef enum logic {
    MODE_STUFF   = 1'b0,
    MODE_UNSTUFF = 1'b1
  } mode_t;

  // results of one accepted byte, ready for the back end
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] res_byte;
    logic [MAX_RES-1:0]      res_bv;
    logic [1:0]              num;
    logic                    last;
    logic                    err;
  } entry_t;

  // front to queue
  typedef struct packed {
    logic   push;
    entry_t ent;
  } q_wr_t;

  // queue head to back
  typedef struct packed {
    logic   valid;
    entry_t ent;
  } q_rd_t;

endpackage

[sv/zbs_if.sv]
// interfaces: input, result and configuration channels of the codec
interface zbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface zbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;
  logic       stuff_error;

  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  output stuff_error, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input out_last,
                input stuff_error, output ready);
endinterface

interface zbs_cfg_if;
  logic valid;
  logic ready;
  logic mode;

  modport source (output valid, output mode, input ready);
  modport sink (input valid, input mode, output ready);
endinterface

[sv/zbs_front.sv]
// front end: takes bytes, runs the bit stuffer state and packs the results
module zbs_front #(
  parameter int unsigned RUN_LIMIT = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  zbs_in_if.sink        in_ch,
  zbs_cfg_if.sink       cfg_ch,
  input  logic          q_full,
  output zbs_pkg::q_wr_t q_wr
);
  import zbs_pkg::*;

  localparam logic [2:0] RunMax = 3'(RUN_LIMIT);

  typedef struct packed {
    logic [7:0]      pbits;
    logic [2:0]      pcnt;
    logic [1:0]      nfull;
    logic [1:0][7:0] full;
  } pack_acc_t;

  mode_t      mode_r;
  logic [2:0] run_r;
  logic       drop_r;
  logic [7:0] pbits_r;
  logic [2:0] pcnt_r;
  logic       err_r;

  pack_acc_t  acc_c;
  logic [2:0] run_c;
  logic       drop_c;
  logic       err_c;
  logic       bit_c;
  entry_t     ent_c;
  logic       take;

  function automatic pack_acc_t put_bit(pack_acc_t a, logic b);
    pack_acc_t r;
    r = a;
    r.pbits[3'd7 - a.pcnt] = b;
    if (a.pcnt == 3'd7) begin
      if (a.nfull != 2'd2) begin
        r.full[a.nfull[0]] = r.pbits;
        r.nfull = a.nfull + 2'd1;
      end
      r.pbits = '0;
      r.pcnt  = '0;
    end else begin
      r.pcnt = a.pcnt + 3'd1;
    end
    return r;
  endfunction

  function automatic logic [2:0] bump(logic [2:0] run);
    return (run == 3'd7) ? run : run + 3'd1;
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign take         = in_ch.valid && !q_full;

  // walk the eight bits msb first
  always_comb begin
    acc_c  = '{pbits: pbits_r, pcnt: pcnt_r, nfull: 2'd0, full: '0};
    run_c  = run_r;
    drop_c = drop_r;
    err_c  = err_r;
    bit_c  = 1'b0;
    for (int i = 0; i < 8; i++) begin
      bit_c = in_ch.data_byte[3'(7 - i)];
      if (!err_c) begin
        if (mode_r == MODE_STUFF) begin
          if (bit_c) begin
            run_c = bump(run_c);
            acc_c = put_bit(acc_c, 1'b1);
            if (run_c >= RunMax) begin
              acc_c = put_bit(acc_c, 1'b0);
              run_c = '0;
            end
          end else begin
            run_c = '0;
            acc_c = put_bit(acc_c, 1'b0);
          end
        end else if (bit_c && drop_c) begin
          // a one where a stuffed zero belongs
          err_c       = 1'b1;
          acc_c.pbits = '0;
          acc_c.pcnt  = '0;
          drop_c      = 1'b0;
          run_c       = '0;
        end else begin
          if (bit_c) begin
            run_c = bump(run_c);
            acc_c = put_bit(acc_c, 1'b1);
          end else begin
            run_c = '0;
            if (drop_c) begin
              drop_c = 1'b0;
            end else begin
              acc_c = put_bit(acc_c, 1'b0);
            end
          end
          if (run_c >= RunMax) begin
            drop_c = 1'b1;
          end
        end
      end
    end
  end

  // build the result list of this byte
  always_comb begin
    ent_c             = '0;
    ent_c.res_byte[0] = acc_c.full[0];
    ent_c.res_byte[1] = acc_c.full[1];
    ent_c.res_bv[0]   = (acc_c.nfull != 2'd0);
    ent_c.res_bv[1]   = (acc_c.nfull == 2'd2);
    ent_c.num         = acc_c.nfull;
    ent_c.last        = in_ch.last_byte;
    ent_c.err         = err_c;
    if (in_ch.last_byte) begin
      if (!err_c && acc_c.pcnt != 3'd0) begin
        ent_c.res_byte[acc_c.nfull] = acc_c.pbits;
        ent_c.res_bv[acc_c.nfull]   = 1'b1;
        ent_c.num                   = acc_c.nfull + 2'd1;
      end else if (acc_c.nfull == 2'd0) begin
        // empty end marker
        ent_c.num = 2'd1;
      end
    end
  end

  assign q_wr.push = take && (ent_c.num != 2'd0);
  assign q_wr.ent  = ent_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STUFF;
      run_r   <= '0;
      drop_r  <= 1'b0;
      pbits_r <= '0;
      pcnt_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        mode_r <= mode_t'(cfg_ch.mode);
      end
      if (take) begin
        if (in_ch.last_byte) begin
          run_r   <= '0;
          drop_r  <= 1'b0;
          pbits_r <= '0;
          pcnt_r  <= '0;
          err_r   <= 1'b0;
        end else begin
          run_r   <= run_c;
          drop_r  <= drop_c;
          pbits_r <= acc_c.pbits;
          pcnt_r  <= acc_c.pcnt;
          err_r   <= err_c;
        end
      end
    end
  end

endmodule

[sv/zbs_queue.sv]
// queue: short register fifo of result lists between front and back
module zbs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  zbs_pkg::q_wr_t q_wr,
  output logic           q_full,
  input  logic           pop,
  output zbs_pkg::q_rd_t q_rd
);
  import zbs_pkg::*;

  localparam int unsigned PtrW = $clog2(Q_DEPTH);
  localparam int unsigned CntW = $clog2(Q_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Q_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Q_DEPTH);

  entry_t          mem_r [Q_DEPTH];
  logic [PtrW-1:0] wptr_r, wptr_nxt;
  logic [PtrW-1:0] rptr_r, rptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign q_full     = (count_r == CntFull);
  assign q_rd.valid = (count_r != '0);
  assign q_rd.ent   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (q_wr.push) begin
      wptr_nxt = (wptr_r == PtrLast) ? '0 : wptr_r + PtrW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PtrLast) ? '0 : rptr_r + PtrW'(1);
    end
    if (q_wr.push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !q_wr.push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wptr_r] <= q_wr.ent;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntFull)
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_push_only_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr.push && !pop) |=> count_r == $past(count_r) + CntW'(1))
    else $error("push not counted");

endmodule

[sv/zbs_back.sv]
// back end: hands out the results of the queue head one request at a time
module zbs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  zbs_pkg::q_rd_t q_rd,
  output logic           pop,
  zbs_out_if.source      out_ch
);
  import zbs_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       final_c;
  logic       fire;

  assign final_c = (idx_r == q_rd.ent.num - 2'd1);
  assign fire    = q_rd.valid && out_ch.ready;
  assign pop     = fire && final_c;

  assign out_ch.valid       = q_rd.valid;
  assign out_ch.out_byte    = q_rd.ent.res_byte[idx_r];
  assign out_ch.byte_valid  = q_rd.ent.res_bv[idx_r];
  assign out_ch.out_last    = q_rd.ent.last && final_c;
  assign out_ch.stuff_error = q_rd.ent.err;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = final_c ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

[sv/zero_bit_stuff_codec.sv]
// top level: zero bit stuffing codec, front end, queue and back end
//
// in_ch takes one byte of a block per request, bits read msb first, last_byte
// marks the end of the block. cfg_ch writes mode (0 stuff, 1 unstuff and
// check); it is always ready, and the user must write it only while the
// block is idle: the block does not enforce this. out_ch gives packed bytes
// msb first; the flush at block end is zero padded and flagged out_last, an
// empty end marker has byte_valid low. the results of a byte are registered
// in the queue and offered from its head. throughput: one byte per cycle
// while each byte yields at most one result and out_ch is ready; a byte that
// yields two or three results holds the single output port until each is
// taken, and the two entry queue then fills and drops in_ch.ready. when the
// receiver stalls out_ch, results wait in the queue and the front keeps
// taking bytes until the queue is full. reset (rst_n low, synchronous) clears
// the queue, the run state, the packing state and sets mode to stuff.
module zero_bit_stuff_codec #(
  parameter int unsigned RUN_LIMIT = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  zbs_in_if.sink     in_ch,
  zbs_out_if.source  out_ch,
  zbs_cfg_if.sink    cfg_ch
);
  import zbs_pkg::*;

  // front to queue write side, queue head to back
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  pop;

  // bit stuffer state and packing, one byte per request
  zbs_front #(
    .RUN_LIMIT (RUN_LIMIT)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // decouples the two sides so each can stall on its own
  zbs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .pop    (pop),
    .q_rd   (q_rd)
  );

  // one result per output request, pops the entry after its final result
  zbs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
